// ----- hw/rtl/osam_pkg.sv -----
// ----------------------------------------------------------------------------
// osam_pkg
// Shared types and constants for the open-sensor alert monitor.
// ----------------------------------------------------------------------------
package osam_pkg;

  // Configuration register widths and reset values
  localparam int unsigned DELAY_W    = 11;
  localparam int unsigned QUIET_W    = 31;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 11'd5;
  localparam logic [QUIET_W-1:0] QUIET_RESET = 31'd30000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_PERIOD = 1'd1;

  // Milliseconds per minute; product with the delay register fits 27 bits
  localparam int unsigned MS_MIN_W = 16;
  localparam logic [MS_MIN_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam int unsigned PROD_W = DELAY_W + MS_MIN_W;

  // Input field widths
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned IN_DATA_W  = 40;  // sensor_open + now_ms, byte padded
  localparam int unsigned OUT_DATA_W = 8;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_PAUSE  = 2'd1,
    MODE_SLEEP  = 2'd2
  } mode_t;

  // Indicator codes
  localparam logic [1:0] IND_CLOSED    = 2'd0;
  localparam logic [1:0] IND_OPEN      = 2'd1;
  localparam logic [1:0] IND_NOTIFIED  = 2'd2;
  localparam logic [1:0] IND_PAUSED    = 2'd3;

  // Result beat, last member in the lowest bit
  typedef struct packed {
    logic       paused_now;
    logic       sleep_allowed;
    logic       notify_close;
    logic       notify_open;
    logic [1:0] indicator;
    logic       indicator_set;
  } result_t;

endpackage

// ----- hw/rtl/open_sensor_alert_monitor.sv -----
// ----------------------------------------------------------------------------
// open_sensor_alert_monitor
// Door/lid sensor monitor on a free-running ms clock: open/close notices,
// pause handling and short-sleep permission, one result beat per input beat.
// Result beat: registered in a single result register, valid the cycle after its input beat is taken.
// Throughput: 1 beat per cycle; s_axis_tready drops only while the result
//   register holds a beat that the sink is not taking.
// Reset: rst (sync, active high) clears all timestamps and pause, empties the
//   result register, and loads delay 5 min / quiet period 30000 ms.
// ----------------------------------------------------------------------------
module open_sensor_alert_monitor #(
  parameter int unsigned TIME_BITS = 32   // timestamp width, 16..64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [osam_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [0] sensor_open, [32:1] now_ms
  input  logic [1:0]                           s_axis_tuser,  // [1:0] mode
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [osam_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [0] indicator_set,
                                                              // [2:1] indicator,
                                                              // [3] notify_open,
                                                              // [4] notify_close,
                                                              // [5] sleep_allowed,
                                                              // [6] paused_now
  // configuration
  input  logic                                 cfg_we,
  input  logic [osam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [osam_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Width used for the quiet-period compare: covers both operands
  localparam int unsigned CMP_W = TIME_BITS + osam_pkg::QUIET_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [osam_pkg::DELAY_W-1:0] notify_delay_minutes;
  logic [osam_pkg::QUIET_W-1:0] quiet_period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      notify_delay_minutes <= osam_pkg::DELAY_RESET;
      quiet_period_ms      <= osam_pkg::QUIET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        osam_pkg::CFG_NOTIFY_DELAY: notify_delay_minutes <= cfg_data[osam_pkg::DELAY_W-1:0];
        osam_pkg::CFG_QUIET_PERIOD: quiet_period_ms      <= cfg_data[osam_pkg::QUIET_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor state
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] opened_at, opened_at_next;
  logic [TIME_BITS-1:0] closed_at, closed_at_next;
  logic [TIME_BITS-1:0] open_notice_at, open_notice_at_next;
  logic [TIME_BITS-1:0] close_notice_at, close_notice_at_next;
  logic                 paused, paused_next;

  // Output register
  osam_pkg::result_t    res, res_next;
  logic                 out_valid;

  // Handshake: take a beat whenever the result register is free or draining
  logic accept;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Field unpacking, resized to the timestamp width
  // --------------------------------------------------------------------------
  logic                                  level;
  logic [osam_pkg::NOW_W-1:0]            now_ms;
  logic [TIME_BITS+osam_pkg::NOW_W-1:0]  now_ext;
  logic [TIME_BITS-1:0]                  now_t;

  assign level   = s_axis_tdata[0];
  assign now_ms  = s_axis_tdata[osam_pkg::NOW_W:1];
  assign now_ext = {{TIME_BITS{1'b0}}, now_ms};
  assign now_t   = now_ext[TIME_BITS-1:0];

  // Open-notice delay in ms, wrapped to the timestamp width
  logic [osam_pkg::PROD_W-1:0]           delay_prod;
  logic [TIME_BITS+osam_pkg::PROD_W-1:0] delay_ext;
  logic [TIME_BITS-1:0]                  delay_ms;

  assign delay_prod = notify_delay_minutes * osam_pkg::MS_PER_MINUTE;
  assign delay_ext  = {{TIME_BITS{1'b0}}, delay_prod};
  assign delay_ms   = delay_ext[TIME_BITS-1:0];

  // Sensor state as held in the timestamps
  logic is_open;
  assign is_open = (opened_at != '0) && (opened_at > closed_at);

  // Elapsed open time for the open notice
  logic [TIME_BITS-1:0] elapsed;
  assign elapsed = now_t - opened_at;

  // Latest activity for the sleep check: two-level max tree
  logic [TIME_BITS-1:0] max_oc, max_nn, last_act, quiet_diff;
  logic [CMP_W-1:0]     diff_ext, quiet_ext;
  logic                 quiet_ok;

  assign max_oc     = (opened_at > closed_at) ? opened_at : closed_at;
  assign max_nn     = (open_notice_at > close_notice_at) ? open_notice_at : close_notice_at;
  assign last_act   = (max_oc > max_nn) ? max_oc : max_nn;
  assign quiet_diff = now_t - last_act;
  assign diff_ext   = {{osam_pkg::QUIET_W{1'b0}}, quiet_diff};
  assign quiet_ext  = {{TIME_BITS{1'b0}}, quiet_period_ms};
  // signed difference: negative never qualifies
  assign quiet_ok   = !quiet_diff[TIME_BITS-1] && (diff_ext > quiet_ext);

  // --------------------------------------------------------------------------
  // Per-beat update
  // --------------------------------------------------------------------------
  always_comb begin
    opened_at_next       = opened_at;
    closed_at_next       = closed_at;
    open_notice_at_next  = open_notice_at;
    close_notice_at_next = close_notice_at;
    paused_next          = paused;
    res_next             = '0;

    case (s_axis_tuser)
      osam_pkg::MODE_SAMPLE: begin
        if (paused) begin
          // Paused: hold indicator until the sensor closes
          res_next.indicator_set = 1'b1;
          res_next.indicator     = osam_pkg::IND_PAUSED;
          if (is_open) begin
            if (!level) begin
              paused_next          = 1'b0;
              opened_at_next       = '0;
              closed_at_next       = '0;
              open_notice_at_next  = '0;
              close_notice_at_next = '0;
            end
          end else if (level) begin
            opened_at_next = now_t;
          end
        end else if (is_open) begin
          if (!level) begin
            closed_at_next         = now_t;
            res_next.indicator_set = 1'b1;
            res_next.indicator     = osam_pkg::IND_CLOSED;
            if (open_notice_at > opened_at) begin
              close_notice_at_next  = now_t;
              res_next.notify_close = 1'b1;
            end
          end else if ((elapsed >= delay_ms) && (open_notice_at < opened_at)) begin
            open_notice_at_next    = now_t;
            res_next.notify_open   = 1'b1;
            res_next.indicator_set = 1'b1;
            res_next.indicator     = osam_pkg::IND_NOTIFIED;
          end
        end else begin
          res_next.indicator_set = 1'b1;
          if (level) begin
            opened_at_next     = now_t;
            res_next.indicator = osam_pkg::IND_OPEN;
          end else begin
            res_next.indicator = osam_pkg::IND_CLOSED;
          end
        end
      end
      osam_pkg::MODE_PAUSE: begin
        paused_next          = !paused && is_open;
        opened_at_next       = '0;
        closed_at_next       = '0;
        open_notice_at_next  = '0;
        close_notice_at_next = '0;
      end
      osam_pkg::MODE_SLEEP: begin
        res_next.sleep_allowed = !paused && !is_open && quiet_ok;
      end
      default: ;  // unused code: no change
    endcase

    res_next.paused_now = paused_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opened_at       <= '0;
      closed_at       <= '0;
      open_notice_at  <= '0;
      close_notice_at <= '0;
      paused          <= 1'b0;
    end else if (accept) begin
      opened_at       <= opened_at_next;
      closed_at       <= closed_at_next;
      open_notice_at  <= open_notice_at_next;
      close_notice_at <= close_notice_at_next;
      paused          <= paused_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, res};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_beat_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted beat did not reach the result register");

  a_one_notice: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.notify_open && res.notify_close))
    else $error("open and close notices in the same beat");

  a_sleep_unpaused: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.sleep_allowed |-> !res.paused_now)
    else $error("sleep allowed while paused");

  a_pause_mirror: assert property (@(posedge clk) disable iff (rst)
    accept |=> (res.paused_now == paused))
    else $error("paused_now differs from pause state");

endmodule

// ----- test/osam_alert_checker.sv -----
// ----------------------------------------------------------------------------
// osam_alert_checker
// Watches the sample and result streams and the register port of the sensor
// monitor, works out each result beat from its own copy of the monitor state,
// and compares the result stream against it in order.
// ----------------------------------------------------------------------------
module osam_alert_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [osam_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [osam_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [osam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [osam_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              results_owed,
  output int                              mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored registers
  logic [osam_pkg::DELAY_W-1:0] delay_min;
  logic [osam_pkg::QUIET_W-1:0] quiet_ms;

  // mirrored monitor state
  logic [osam_pkg::NOW_W-1:0] opened_at;
  logic [osam_pkg::NOW_W-1:0] closed_at;
  logic [osam_pkg::NOW_W-1:0] open_notice_at;
  logic [osam_pkg::NOW_W-1:0] close_notice_at;
  logic                       paused;

  osam_pkg::result_t alert_results_due[$];
  int                beat_no;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned seen);
    $display("%0t: result beat %0d, %s: expected %0d, got %0d",
             $time, beat_no, what, want, seen);
    mismatch_count++;
  endtask

  function automatic void clear_stamps();
    opened_at       = '0;
    closed_at       = '0;
    open_notice_at  = '0;
    close_notice_at = '0;
  endfunction

  // Advances the mirrored state by one sample beat and returns its result.
  function automatic osam_pkg::result_t next_alert_result(
      input logic [1:0] kind,
      input logic level,
      input logic [osam_pkg::NOW_W-1:0] stamp);
    osam_pkg::result_t          r;
    logic                       was_open;
    logic [osam_pkg::NOW_W-1:0] notice_delay;
    logic [osam_pkg::NOW_W-1:0] elapsed;
    logic [osam_pkg::NOW_W-1:0] latest;
    logic [osam_pkg::NOW_W-1:0] quiet_gap;
    r        = '0;
    was_open = (opened_at != '0) && (opened_at > closed_at);
    case (kind)
      osam_pkg::MODE_SAMPLE: begin
        if (paused) begin
          r.indicator_set = 1'b1;
          r.indicator     = osam_pkg::IND_PAUSED;
          if (was_open) begin
            if (!level) begin
              paused = 1'b0;
              clear_stamps();
            end
          end else if (level) begin
            opened_at = stamp;
          end
        end else if (was_open) begin
          if (!level) begin
            closed_at       = stamp;
            r.indicator_set = 1'b1;
            r.indicator     = osam_pkg::IND_CLOSED;
            if (open_notice_at > opened_at) begin
              close_notice_at = stamp;
              r.notify_close  = 1'b1;
            end
          end else begin
            notice_delay = osam_pkg::NOW_W'(delay_min) * osam_pkg::NOW_W'(32'd60000);
            elapsed      = stamp - opened_at;
            if (elapsed >= notice_delay && open_notice_at < opened_at) begin
              open_notice_at  = stamp;
              r.notify_open   = 1'b1;
              r.indicator_set = 1'b1;
              r.indicator     = osam_pkg::IND_NOTIFIED;
            end
          end
        end else begin
          r.indicator_set = 1'b1;
          if (level) begin
            opened_at   = stamp;
            r.indicator = osam_pkg::IND_OPEN;
          end else begin
            r.indicator = osam_pkg::IND_CLOSED;
          end
        end
      end
      osam_pkg::MODE_PAUSE: begin
        paused = !paused && was_open;
        clear_stamps();
      end
      osam_pkg::MODE_SLEEP: begin
        if (!paused && !was_open) begin
          latest = (opened_at > closed_at) ? opened_at : closed_at;
          if (open_notice_at > latest) latest = open_notice_at;
          if (close_notice_at > latest) latest = close_notice_at;
          quiet_gap = stamp - latest;
          // a gap with the top bit set counts as negative: never quiet
          r.sleep_allowed = !quiet_gap[osam_pkg::NOW_W-1] &&
                            (quiet_gap > osam_pkg::NOW_W'(quiet_ms));
        end
      end
      default: ;  // spare kind leaves everything alone
    endcase
    r.paused_now = paused;
    return r;
  endfunction

  always @(posedge clk) begin
    osam_pkg::result_t want;
    osam_pkg::result_t seen;
    if (rst) begin
      delay_min = osam_pkg::DELAY_RESET;
      quiet_ms  = osam_pkg::QUIET_RESET;
      paused    = 1'b0;
      clear_stamps();
      alert_results_due.delete();
      beat_no = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == osam_pkg::CFG_NOTIFY_DELAY) delay_min = cfg_data[osam_pkg::DELAY_W-1:0];
        else                                         quiet_ms  = cfg_data[osam_pkg::QUIET_W-1:0];
      end
      // results first: a beat accepted at this edge cannot have its result yet
      if (m_tvalid && m_tready) begin
        seen = osam_pkg::result_t'(m_tdata[$bits(osam_pkg::result_t)-1:0]);
        if (alert_results_due.size() == 0) begin
          report_mismatch("beats outstanding", 0, 1);
        end else begin
          want = alert_results_due.pop_front();
          if (seen.indicator_set != want.indicator_set)
            report_mismatch("indicator_set", 32'(want.indicator_set),
                            32'(seen.indicator_set));
          if (seen.indicator != want.indicator)
            report_mismatch("indicator", 32'(want.indicator), 32'(seen.indicator));
          if (seen.notify_open != want.notify_open)
            report_mismatch("notify_open", 32'(want.notify_open),
                            32'(seen.notify_open));
          if (seen.notify_close != want.notify_close)
            report_mismatch("notify_close", 32'(want.notify_close),
                            32'(seen.notify_close));
          if (seen.sleep_allowed != want.sleep_allowed)
            report_mismatch("sleep_allowed", 32'(want.sleep_allowed),
                            32'(seen.sleep_allowed));
          if (seen.paused_now != want.paused_now)
            report_mismatch("paused_now", 32'(want.paused_now),
                            32'(seen.paused_now));
        end
        beat_no++;
      end
      if (s_tvalid && s_tready)
        alert_results_due.push_back(next_alert_result(s_tuser, s_tdata[0],
                                                       s_tdata[osam_pkg::NOW_W:1]));
    end
    results_owed <= alert_results_due.size();
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives sensor samples, pause toggles and sleep queries into the open-sensor
// alert monitor across several register settings, with random idling on both
// streams; the checker alongside predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // kind value the package leaves unnamed; the block must ignore it
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // how long the sink refuses beats when asked to hold off
  localparam int HOLD_CYCLES = 150;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [osam_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [0] sensor_open, [32:1] now_ms
  logic [1:0]                      s_axis_tuser;   // [1:0] mode
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [osam_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // [0] indicator_set, [2:1] indicator,
                                                   // [3] notify_open, [4] notify_close,
                                                   // [5] sleep_allowed, [6] paused_now
  logic                            cfg_we;
  logic [osam_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [osam_pkg::CFG_DATA_W-1:0] cfg_data;

  int results_owed;
  int mismatch_count;

  // idling controls shared between the sender and the sink
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_req  = 1'b0;

  // running millisecond clock and door level for the well-formed traffic
  logic [osam_pkg::NOW_W-1:0] clock_ms;
  logic                       door_open;

  open_sensor_alert_monitor #(.TIME_BITS(osam_pkg::NOW_W)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  osam_alert_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_axis_tvalid),
    .s_tready       (s_axis_tready),
    .s_tdata        (s_axis_tdata),
    .s_tuser        (s_axis_tuser),
    .m_tvalid       (m_axis_tvalid),
    .m_tready       (m_axis_tready),
    .m_tdata        (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sink: random back-pressure, or a long hold-off when asked. The hold is
  // counted here so the sender keeps offering beats and the block backs up.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(sink_gaps && $urandom_range(99) < 32);
      end
    end
  end

  // One input beat; tvalid stays up across back-to-back beats and is only
  // dropped for an idle gap. Returns on the edge that takes the beat.
  task automatic send_beat(input logic [1:0] kind, input logic level,
                           input logic [osam_pkg::NOW_W-1:0] stamp);
    if (src_gaps) begin
      while ($urandom_range(99) < 32) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(osam_pkg::IN_DATA_W-osam_pkg::NOW_W-1){1'b0}}, stamp, level};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Wait until every result owed has been taken. The count is registered and
  // lags the queue, so always look past the last beat.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [osam_pkg::CFG_IDX_W-1:0] idx,
                           input logic [osam_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small steps, now and then long enough for the 1440-minute notice
  // delay, and rarely an arbitrary jump (backwards or across the wrap).
  function automatic logic [osam_pkg::NOW_W-1:0] time_step();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)      return osam_pkg::NOW_W'($urandom_range(5000));
    else if (pick < 85) return osam_pkg::NOW_W'($urandom_range(400000));
    else if (pick < 97) return osam_pkg::NOW_W'($urandom_range(100_000_000));
    else                return osam_pkg::NOW_W'($urandom());
  endfunction

  // Door-like traffic with random timing, plus a share of pure noise.
  task automatic random_event();
    int unsigned pick;
    pick     = $urandom_range(99);
    clock_ms = clock_ms + time_step();
    if (pick < 10) begin
      send_beat(2'($urandom_range(3)), 1'($urandom_range(1)),
                osam_pkg::NOW_W'($urandom()));
    end else if (pick < 18) begin
      send_beat(osam_pkg::MODE_PAUSE, 1'($urandom_range(1)), clock_ms);
    end else if (pick < 35) begin
      send_beat(osam_pkg::MODE_SLEEP, 1'($urandom_range(1)), clock_ms);
    end else begin
      if ($urandom_range(3) == 0) door_open = !door_open;
      send_beat(osam_pkg::MODE_SAMPLE, door_open, clock_ms);
    end
  endtask

  task automatic run_events(input int count);
    repeat (count) random_event();
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= osam_pkg::MODE_SAMPLE;
    cfg_we        <= 1'b0;
    cfg_index     <= osam_pkg::CFG_NOTIFY_DELAY;
    cfg_data      <= '0;
    clock_ms      = '0;
    door_open     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset settings: 5 min delay, 30 s quiet ----
    send_beat(osam_pkg::MODE_SLEEP,  1'b0, 32'd0);          // nothing recorded, no gap
    send_beat(osam_pkg::MODE_SLEEP,  1'b0, 32'd30001);      // just past the quiet period
    send_beat(osam_pkg::MODE_SAMPLE, 1'b0, 32'd100);        // closed stays closed
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd0);          // opens at time zero: not open
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd1000);       // real open
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd200000);     // too early for the notice
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd301000);     // open notice fires
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd400000);     // notice only once
    send_beat(osam_pkg::MODE_SLEEP,  1'b0, 32'd500000);     // open: no sleep
    send_beat(osam_pkg::MODE_SAMPLE, 1'b0, 32'd500000);     // close with close notice
    send_beat(osam_pkg::MODE_SLEEP,  1'b1, 32'd500010);     // not quiet yet
    send_beat(osam_pkg::MODE_SLEEP,  1'b0, 32'hFFFF_FFFF);  // negative gap
    send_beat(osam_pkg::MODE_PAUSE,  1'b0, 32'd7);          // pause while closed
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'hFFFF_FFF0);
    send_beat(osam_pkg::MODE_PAUSE,  1'b1, 32'hFFFF_FFF8);  // pause while open
    send_beat(osam_pkg::MODE_SLEEP,  1'b0, 32'h7000_0000);  // paused: no sleep
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd5);          // opens during pause
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'd9);          // still paused
    send_beat(osam_pkg::MODE_SAMPLE, 1'b0, 32'd20);         // close ends the pause
    send_beat(MODE_SPARE,            1'b1, 32'hFFFF_FFFF);  // spare kind is ignored
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'h8000_0000);
    send_beat(osam_pkg::MODE_SAMPLE, 1'b1, 32'h0000_0010);  // elapsed time wraps
    send_beat(osam_pkg::MODE_SAMPLE, 1'b0, 32'd5);          // close earlier than open
    send_beat(osam_pkg::MODE_PAUSE,  1'b0, 32'd6);

    // ---- random part at reset settings ----
    run_events(120);

    // ---- zero delay, zero quiet ----
    wait_all_results();
    write_reg(osam_pkg::CFG_NOTIFY_DELAY, '0);
    write_reg(osam_pkg::CFG_QUIET_PERIOD, '0);
    run_events(140);

    // ---- 1440-minute delay and longest quiet period; long sink hold-off ----
    wait_all_results();
    write_reg(osam_pkg::CFG_NOTIFY_DELAY, osam_pkg::CFG_DATA_W'(1440));
    write_reg(osam_pkg::CFG_QUIET_PERIOD, osam_pkg::CFG_DATA_W'(31'h7FFF_FFFF));
    run_events(40);
    src_gaps = 1'b0;
    hold_req = 1'b1;   // sink stops; sender keeps going until the block stalls
    run_events(25);
    src_gaps = 1'b1;
    run_events(75);

    // ---- short settings; stretch with no idling on either side ----
    wait_all_results();
    write_reg(osam_pkg::CFG_NOTIFY_DELAY, osam_pkg::CFG_DATA_W'(1));
    write_reg(osam_pkg::CFG_QUIET_PERIOD, osam_pkg::CFG_DATA_W'(1000));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    run_events(100);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    wait_all_results();   // sender waits for everything mid-phase
    run_events(40);

    // ---- random settings; delay word carries junk above its width ----
    wait_all_results();
    write_reg(osam_pkg::CFG_NOTIFY_DELAY, osam_pkg::CFG_DATA_W'($urandom()));
    write_reg(osam_pkg::CFG_QUIET_PERIOD, osam_pkg::CFG_DATA_W'($urandom()));
    run_events(80);

    // ---- back to reset values ----
    wait_all_results();
    write_reg(osam_pkg::CFG_NOTIFY_DELAY, osam_pkg::CFG_DATA_W'(osam_pkg::DELAY_RESET));
    write_reg(osam_pkg::CFG_QUIET_PERIOD, osam_pkg::CFG_DATA_W'(osam_pkg::QUIET_RESET));
    run_events(80);

    wait_all_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/osam_pkg.sv
hw/rtl/open_sensor_alert_monitor.sv
test/osam_alert_checker.sv
test/testbench.sv
